### sv/rrbc_pkg.sv
package rrbc_pkg;

    localparam int COORD_BITS_DEFAULT = 16;

endpackage

### sv/rrbc_prep.sv
// Stage 1: box corners (combinational), then registered edge vectors, point offsets and corner-in-box flags.
module rrbc_prep #(
    parameter int CB = rrbc_pkg::COORD_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [CB-1:0]  qx [4],
    input  logic signed [CB-1:0]  qy [4],
    input  logic signed [CB-1:0]  left,
    input  logic signed [CB-1:0]  top,
    input  logic        [CB-2:0]  width,
    input  logic        [CB-2:0]  height,
    output logic signed [CB+1:0]  qex_reg [4],
    output logic signed [CB+1:0]  qey_reg [4],
    output logic signed [CB+1:0]  bex_reg [4],
    output logic signed [CB+1:0]  bey_reg [4],
    output logic signed [CB+1:0]  offx_reg [4][4],
    output logic signed [CB+1:0]  offy_reg [4][4],
    output logic        [3:0]     cin_reg
);
    import rrbc_pkg::*;

    localparam int W = CB + 2;

    logic signed [W-1:0] bx [4];
    logic signed [W-1:0] by [4];
    logic signed [W-1:0] px [4];
    logic signed [W-1:0] py [4];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            px[i] = W'(qx[i]);
            py[i] = W'(qy[i]);
        end
        bx[0] = W'(left);
        by[0] = W'(top);
        bx[1] = W'(left) + W'({1'b0, width});
        by[1] = W'(top);
        bx[2] = bx[1];
        by[2] = W'(top) + W'({1'b0, height});
        bx[3] = W'(left);
        by[3] = by[2];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                qex_reg[i] <= px[(i + 1) % 4] - px[i];
                qey_reg[i] <= py[(i + 1) % 4] - py[i];
                bex_reg[i] <= bx[(i + 1) % 4] - bx[i];
                bey_reg[i] <= by[(i + 1) % 4] - by[i];
                cin_reg[i] <= (px[i] >= bx[0]) && (px[i] <= bx[2])
                           && (py[i] >= by[0]) && (py[i] <= by[2]);
                // Offset from quad corner i to box corner j.
                for (int j = 0; j < 4; j++)
                begin
                    offx_reg[i][j] <= bx[j] - px[i];
                    offy_reg[i][j] <= by[j] - py[i];
                end
            end
        end
    end
endmodule

### sv/rrbc_cross.sv
// Stage 2: all products; stage 3: cross products by subtraction.
module rrbc_cross #(
    parameter int CB = rrbc_pkg::COORD_BITS_DEFAULT
) (
    input  logic                    clk,
    input  logic                    en2,
    input  logic                    en3,
    input  logic signed [CB+1:0]    qex [4],
    input  logic signed [CB+1:0]    qey [4],
    input  logic signed [CB+1:0]    bex [4],
    input  logic signed [CB+1:0]    bey [4],
    input  logic signed [CB+1:0]    offx [4][4],
    input  logic signed [CB+1:0]    offy [4][4],
    output logic signed [2*CB+4:0]  den_reg [4][4],
    output logic signed [2*CB+4:0]  tn_reg [4][4],
    output logic signed [2*CB+4:0]  un_reg [4][4],
    output logic signed [2*CB+4:0]  pq_reg [4][4]
);
    import rrbc_pkg::*;

    localparam int P = 2 * CB + 4;
    localparam int X = 2 * CB + 5;

    logic signed [P-1:0] d_a [4][4], d_b [4][4];
    logic signed [P-1:0] t_a [4][4], t_b [4][4];
    logic signed [P-1:0] u_a [4][4], u_b [4][4];
    logic signed [P-1:0] p_a [4][4], p_b [4][4];

    // Edge pair (i,j): d = cross product of quad edge i and box edge j.
    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            for (int i = 0; i < 4; i++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    d_a[i][j] <= qex[i] * bey[j];
                    d_b[i][j] <= qey[i] * bex[j];
                    t_a[i][j] <= offx[i][j] * bey[j];
                    t_b[i][j] <= offy[i][j] * bex[j];
                    u_a[i][j] <= offx[i][j] * qey[i];
                    u_b[i][j] <= offy[i][j] * qex[i];
                    p_a[i][j] <= qex[i] * offy[i][j];
                    p_b[i][j] <= qey[i] * offx[i][j];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            for (int i = 0; i < 4; i++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    den_reg[i][j] <= X'(d_a[i][j]) - X'(d_b[i][j]);
                    tn_reg[i][j]  <= X'(t_a[i][j]) - X'(t_b[i][j]);
                    un_reg[i][j]  <= X'(u_a[i][j]) - X'(u_b[i][j]);
                    pq_reg[i][j]  <= X'(p_a[i][j]) - X'(p_b[i][j]);
                end
            end
        end
    end
endmodule

### sv/rrbc_decide.sv
// Stage 4: range checks, box-corner-in-quad sign checks and the final flag.
module rrbc_decide #(
    parameter int CB = rrbc_pkg::COORD_BITS_DEFAULT
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic                    cin_any,
    input  logic signed [2*CB+4:0]  den [4][4],
    input  logic signed [2*CB+4:0]  tn [4][4],
    input  logic signed [2*CB+4:0]  un [4][4],
    input  logic signed [2*CB+4:0]  pq [4][4],
    output logic                    hit_reg
);
    import rrbc_pkg::*;

    localparam int X = 2 * CB + 5;

    logic hit;

    function automatic logic in_unit(input logic signed [X-1:0] n,
                                     input logic signed [X-1:0] d);
        logic pos;
        begin
            pos = !d[X-1];
            if (pos)
                in_unit = !n[X-1] && (n <= d);
            else
                in_unit = (n[X-1] || n == '0) && (n >= d);
        end
    endfunction

    always_comb
    begin
        logic p, m;
        hit = cin_any;
        for (int j = 0; j < 4; j++)
        begin
            p = 1'b0;
            m = 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                if (pq[i][j] > 0)
                    p = 1'b1;
                if (pq[i][j] < 0)
                    m = 1'b1;
            end
            if (p ^ m)
                hit = 1'b1;
        end
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                if (den[i][j] != '0 && in_unit(tn[i][j], den[i][j])
                    && in_unit(un[i][j], den[i][j]))
                    hit = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            hit_reg <= hit;
    end
endmodule

### sv/rotated_rect_box_collision_core.sv
// Channel | Signals                                   | Direction
// in      | in_valid, in_ready, corner*, box_*         | into the core
// out     | out_valid, out_ready, collides            | out of the core
//
// Five register stages: prepare, products, cross differences, decide, output.
// One item per cycle when out_ready is high; out_valid is the last stage's bit.
// rst_n clears only the stage valid bits; data registers are not reset.
// A stage advances when it is empty or the stage after it advances, so a stall
// at the output holds every occupied stage and drops nothing.
module rotated_rect_box_collision_core #(
    parameter int COORD_BITS = rrbc_pkg::COORD_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_BITS-1:0]  corner0_x,
    input  logic signed [COORD_BITS-1:0]  corner0_y,
    input  logic signed [COORD_BITS-1:0]  corner1_x,
    input  logic signed [COORD_BITS-1:0]  corner1_y,
    input  logic signed [COORD_BITS-1:0]  corner2_x,
    input  logic signed [COORD_BITS-1:0]  corner2_y,
    input  logic signed [COORD_BITS-1:0]  corner3_x,
    input  logic signed [COORD_BITS-1:0]  corner3_y,
    input  logic signed [COORD_BITS-1:0]  box_left,
    input  logic signed [COORD_BITS-1:0]  box_top,
    input  logic        [COORD_BITS-2:0]  box_width,
    input  logic        [COORD_BITS-2:0]  box_height,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          collides
);
    import rrbc_pkg::*;

    localparam int CB = COORD_BITS;

    logic [4:0] v_reg, v_next;
    logic [4:0] adv;

    logic signed [CB-1:0]   qx [4], qy [4];
    logic signed [CB+1:0]   qex [4], qey [4], bex [4], bey [4];
    logic signed [CB+1:0]   offx [4][4], offy [4][4];
    logic        [3:0]      cin;
    logic signed [2*CB+4:0] den [4][4], tn [4][4], un [4][4], pq [4][4];
    logic                   cin2_reg, cin3_reg;
    logic                   hit;
    logic                   collides_reg;

    always_comb
    begin
        adv[4] = !v_reg[4] || out_ready;
        for (int s = 3; s >= 0; s--)
            adv[s] = !v_reg[s] || adv[s + 1];
    end

    assign in_ready  = adv[0];
    assign out_valid = v_reg[4];
    assign collides  = collides_reg;

    always_comb
    begin
        v_next = v_reg;
        if (adv[0])
            v_next[0] = in_valid;
        for (int s = 1; s < 5; s++)
            if (adv[s])
                v_next[s] = v_reg[s - 1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign qx[0] = corner0_x;
    assign qy[0] = corner0_y;
    assign qx[1] = corner1_x;
    assign qy[1] = corner1_y;
    assign qx[2] = corner2_x;
    assign qy[2] = corner2_y;
    assign qx[3] = corner3_x;
    assign qy[3] = corner3_y;

    rrbc_prep #(.CB(CB)) u_prep (
        .clk(clk), .en(adv[0]), .qx(qx), .qy(qy), .left(box_left), .top(box_top),
        .width(box_width), .height(box_height), .qex_reg(qex), .qey_reg(qey),
        .bex_reg(bex), .bey_reg(bey), .offx_reg(offx), .offy_reg(offy),
        .cin_reg(cin)
    );

    rrbc_cross #(.CB(CB)) u_cross (
        .clk(clk), .en2(adv[1]), .en3(adv[2]), .qex(qex), .qey(qey),
        .bex(bex), .bey(bey), .offx(offx), .offy(offy),
        .den_reg(den), .tn_reg(tn), .un_reg(un), .pq_reg(pq)
    );

    always_ff @(posedge clk)
    begin
        if (adv[1])
            cin2_reg <= |cin;
        if (adv[2])
            cin3_reg <= cin2_reg;
    end

    rrbc_decide #(.CB(CB)) u_decide (
        .clk(clk), .en(adv[3]), .cin_any(cin3_reg), .den(den), .tn(tn),
        .un(un), .pq(pq), .hit_reg(hit)
    );

    always_ff @(posedge clk)
    begin
        if (adv[4])
            collides_reg <= hit;
    end

    ap_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(collides))
        else $error("result changed under stall");
    ap_noready: assert property (@(posedge clk) disable iff (!rst_n)
        &v_reg && !out_ready |-> !in_ready)
        else $error("full pipe accepted input");
    ap_flow: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> v_reg[0])
        else $error("accepted item lost at stage one");
endmodule
